### rtl/assert_macros.svh
// Assertion helpers; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SCSC_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scsc check failed");

// Next-cycle implication.
`define SCSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scsc check failed");

`endif

### rtl/scsc_pkg.sv
package scsc_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int STEP_W    = $clog2(2 * NUM_SLOTS + 2);
    localparam int SEC_W     = 32;
    localparam int TYPE_W    = 2;
    localparam int OUTC_W    = 3;
    localparam int IN_DW     = 2 * SEC_W;
    localparam int OUT_DW    = ((SLOT_W + 2 + SEC_W + 7) / 8) * 8;

    localparam logic [TYPE_W-1:0] REQ_READ  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_RA    = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_FLUSH = 2'd3;

    localparam logic [OUTC_W-1:0] OUT_HIT        = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_FILL       = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_EVICT      = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_SKIP       = 3'd3;
    localparam logic [OUTC_W-1:0] OUT_FLUSH_WR   = 3'd4;
    localparam logic [OUTC_W-1:0] OUT_FLUSH_NONE = 3'd5;

    localparam logic [SEC_W-1:0] NO_SECTOR = '1;

    typedef struct packed {
        logic [OUTC_W-1:0] outcome;
        logic [SLOT_W-1:0] slot;
        logic              rd;
        logic              wr;
        logic [SEC_W-1:0]  wsec;
        logic              last;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SEC_W-1:0]  wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [SLOT_W-1:0] adv(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic t_res mk_res(input logic [OUTC_W-1:0] outcome,
                                    input logic [SLOT_W-1:0] slot,
                                    input logic rd, input logic wr,
                                    input logic [SEC_W-1:0] wsec,
                                    input logic last);
        t_res r;
        r.outcome = outcome;
        r.slot    = slot;
        r.rd      = rd;
        r.wr      = wr;
        r.wsec    = wsec;
        r.last    = last;
        return r;
    endfunction

endpackage

### rtl/scsc_tag_ram.sv
module scsc_tag_ram (
    input  logic                    i_clk,
    input  scsc_pkg::t_ram_req      i_req,
    output logic [scsc_pkg::SEC_W-1:0] o_rdata
);
    import scsc_pkg::*;

    logic [SEC_W-1:0] r_mem [NUM_SLOTS];
    logic [SEC_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

### rtl/scsc_seq.sv
module scsc_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_vld,
    output logic                         o_in_rdy,
    input  logic [scsc_pkg::TYPE_W-1:0]  i_type,
    input  logic [scsc_pkg::SEC_W-1:0]   i_sec,
    input  logic [scsc_pkg::SEC_W-1:0]   i_prot,
    output logic                         o_res_vld,
    input  logic                         i_res_rdy,
    output scsc_pkg::t_res               o_res,
    output scsc_pkg::t_ram_req           o_ram,
    input  logic [scsc_pkg::SEC_W-1:0]   i_rdata
);
    import scsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_SWEEP, S_VRD, S_VTAG, S_FL_CHK, S_FL_TAG, S_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic [TYPE_W-1:0]    r_type, n_type;
    logic [SEC_W-1:0]     r_sec, n_sec;
    logic [SEC_W-1:0]     r_prot, n_prot;
    logic [CNT_W-1:0]     r_addr, n_addr;     // lookup address / flush visit count
    logic                 r_pv, n_pv;         // a tag read is in flight
    logic [SLOT_W-1:0]    r_pidx, n_pidx;
    logic [SLOT_W-1:0]    r_saddr, n_saddr;   // sweep / flush pointer
    logic [STEP_W-1:0]    r_n, n_n;
    logic [SLOT_W-1:0]    r_hand, n_hand;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [SLOT_W-1:0]    r_victim, n_victim;
    logic                 r_have, n_have;     // flush entry held back until next is known
    logic [SLOT_W-1:0]    r_pslot, n_pslot;
    logic [SEC_W-1:0]     r_ptag, n_ptag;
    logic [NUM_SLOTS-1:0] r_ref, n_ref;
    logic [NUM_SLOTS-1:0] r_dirty, n_dirty;
    t_res                 r_res, n_res;

    logic hit, prot_hit;
    t_res skip_res;

    assign hit      = r_pv && (i_rdata == r_sec);
    assign prot_hit = (r_type == REQ_RA) && (i_rdata == r_prot);
    assign skip_res = mk_res(OUT_SKIP, '0, 1'b0, 1'b0, '0, 1'b1);

    always_comb begin
        n_state  = r_state;
        n_type   = r_type;
        n_sec    = r_sec;
        n_prot   = r_prot;
        n_addr   = r_addr;
        n_pv     = r_pv;
        n_pidx   = r_pidx;
        n_saddr  = r_saddr;
        n_n      = r_n;
        n_hand   = r_hand;
        n_fill   = r_fill;
        n_victim = r_victim;
        n_have   = r_have;
        n_pslot  = r_pslot;
        n_ptag   = r_ptag;
        n_ref    = r_ref;
        n_dirty  = r_dirty;
        n_res    = r_res;
        o_ram    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_vld) begin
                    n_type = i_type;
                    n_sec  = i_sec;
                    n_prot = i_prot;
                    n_addr = '0;
                    n_pv   = 1'b0;
                    if (i_type == REQ_FLUSH) begin
                        n_saddr = r_hand;
                        n_have  = 1'b0;
                        n_state = S_FL_CHK;
                    end else if (i_type == REQ_RA && i_sec == NO_SECTOR) begin
                        n_res   = skip_res;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (hit) begin
                    // read-ahead of a cached sector leaves the entry untouched
                    if (r_type == REQ_RA) begin
                        n_res = skip_res;
                    end else begin
                        n_ref[r_pidx] = 1'b1;
                        if (r_type == REQ_WRITE) begin
                            n_dirty[r_pidx] = 1'b1;
                        end
                        n_res = mk_res(OUT_HIT, r_pidx, 1'b0, 1'b0, '0, 1'b1);
                    end
                    n_pv    = 1'b0;
                    n_state = S_EMIT;
                end else if (!r_pv && r_addr >= r_fill) begin
                    if (r_fill < CNT_W'(NUM_SLOTS)) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_fill[SLOT_W-1:0];
                        o_ram.wdata = r_sec;
                        n_ref[r_fill[SLOT_W-1:0]]   = 1'b1;
                        n_dirty[r_fill[SLOT_W-1:0]] = (r_type == REQ_WRITE);
                        n_fill  = CNT_W'(r_fill + 1'b1);
                        n_res   = mk_res(OUT_FILL, r_fill[SLOT_W-1:0], 1'b1, 1'b0, '0, 1'b1);
                        n_state = S_EMIT;
                    end else begin
                        n_saddr = r_hand;
                        n_pv    = 1'b0;
                        n_n     = '0;
                        n_state = S_SWEEP;
                    end
                end else if (r_addr < r_fill) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_addr[SLOT_W-1:0];
                    n_pidx = r_addr[SLOT_W-1:0];
                    n_addr = CNT_W'(r_addr + 1'b1);
                    n_pv   = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
            end
            S_SWEEP: begin
                if (r_pv && !(r_ref[r_pidx] || prot_hit)) begin
                    n_victim = r_pidx;
                    n_hand   = adv(r_pidx);
                    n_pv     = 1'b0;
                    n_state  = S_VRD;
                end else if (r_pv && r_n == STEP_W'(2 * NUM_SLOTS)) begin
                    // bound reached: take the slot after the one under the hand
                    n_ref[r_pidx] = 1'b0;
                    n_victim = adv(r_pidx);
                    n_hand   = adv(adv(r_pidx));
                    n_pv     = 1'b0;
                    n_state  = S_VRD;
                end else begin
                    if (r_pv) begin
                        n_ref[r_pidx] = 1'b0;
                        n_hand = adv(r_pidx);
                        n_n    = STEP_W'(r_n + 1'b1);
                    end
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_saddr;
                    n_pidx  = r_saddr;
                    n_saddr = adv(r_saddr);
                    n_pv    = 1'b1;
                end
            end
            S_VRD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = r_victim;
                n_state     = S_VTAG;
            end
            S_VTAG: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_victim;
                o_ram.wdata = r_sec;
                n_res = mk_res(OUT_EVICT, r_victim, 1'b1, r_dirty[r_victim],
                               r_dirty[r_victim] ? i_rdata : '0, 1'b1);
                n_ref[r_victim]   = 1'b1;
                n_dirty[r_victim] = (r_type == REQ_WRITE);
                n_state = S_EMIT;
            end
            S_FL_CHK: begin
                if (r_addr == r_fill) begin
                    if (r_have) begin
                        n_res = mk_res(OUT_FLUSH_WR, r_pslot, 1'b0, 1'b1, r_ptag, 1'b1);
                    end else begin
                        n_res = mk_res(OUT_FLUSH_NONE, '0, 1'b0, 1'b0, '0, 1'b1);
                    end
                    n_state = S_EMIT;
                end else begin
                    if (r_dirty[r_saddr]) begin
                        n_dirty[r_saddr] = 1'b0;
                        o_ram.re    = 1'b1;
                        o_ram.raddr = r_saddr;
                        n_victim    = r_saddr;
                        n_state     = S_FL_TAG;
                    end
                    n_saddr = adv(r_saddr);
                    n_addr  = CNT_W'(r_addr + 1'b1);
                end
            end
            S_FL_TAG: begin
                n_pslot = r_victim;
                n_ptag  = i_rdata;
                n_have  = 1'b1;
                if (r_have) begin
                    n_res   = mk_res(OUT_FLUSH_WR, r_pslot, 1'b0, 1'b1, r_ptag, 1'b0);
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FL_CHK;
                end
            end
            S_EMIT: begin
                if (i_res_rdy) begin
                    n_state = r_res.last ? S_IDLE : S_FL_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_hand  <= '0;
            r_fill  <= '0;
            r_have  <= 1'b0;
            r_ref   <= '0;
            r_dirty <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_hand  <= n_hand;
            r_fill  <= n_fill;
            r_have  <= n_have;
            r_ref   <= n_ref;
            r_dirty <= n_dirty;
        end
        r_type   <= n_type;
        r_sec    <= n_sec;
        r_prot   <= n_prot;
        r_addr   <= n_addr;
        r_pidx   <= n_pidx;
        r_saddr  <= n_saddr;
        r_n      <= n_n;
        r_victim <= n_victim;
        r_pslot  <= n_pslot;
        r_ptag   <= n_ptag;
        r_res    <= n_res;
    end

    assign o_in_rdy  = (r_state == S_IDLE);
    assign o_res_vld = (r_state == S_EMIT);
    assign o_res     = r_res;

endmodule

### rtl/sector_cache_second_chance.sv
// Lookup: a hit is found by a linear tag search in slot order; a miss fills a free slot, or
// when all slots are filled, evicts one chosen by a bounded second-chance sweep from the hand.
// Flush: visits every filled slot and gives one result per dirty entry, or FLUSH_NONE if none.
// One request at a time; tag search and sweep share one tag RAM read port.
// Reset (i_rst_n low, synchronous) clears reference/dirty bits, fill count and hand;
// the tag RAM is not cleared, it is only read below the fill count.
`include "assert_macros.svh"

module sector_cache_second_chance (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [scsc_pkg::IN_DW-1:0]    i_s_axis_tdata,   // sector, protect_sector
    input  logic [scsc_pkg::TYPE_W-1:0]   i_s_axis_tuser,   // req_type
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [scsc_pkg::OUT_DW-1:0]   o_m_axis_tdata,   // slot, disk_read_needed,
                                                            // disk_write_needed,
                                                            // disk_write_sector
    output logic [scsc_pkg::OUTC_W-1:0]   o_m_axis_tuser,   // outcome
    output logic                          o_m_axis_tlast
);
    import scsc_pkg::*;

    t_ram_req          ram_req;
    logic [SEC_W-1:0]  ram_q;
    logic              res_vld, res_rdy;
    t_res              res;
    logic              r_out_vld;
    t_res              r_out;
    logic              out_hit, out_evict, out_flush_wr;

    scsc_tag_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_q)
    );

    scsc_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (i_s_axis_tvalid),
        .o_in_rdy  (o_s_axis_tready),
        .i_type    (i_s_axis_tuser),
        .i_sec     (i_s_axis_tdata[SEC_W-1:0]),
        .i_prot    (i_s_axis_tdata[2*SEC_W-1:SEC_W]),
        .o_res_vld (res_vld),
        .i_res_rdy (res_rdy),
        .o_res     (res),
        .o_ram     (ram_req),
        .i_rdata   (ram_q)
    );

    // output register; refilled in the cycle the previous item leaves
    assign res_rdy = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && res_rdy) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (res_vld && res_rdy) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_DW'({r_out.wsec, r_out.wr, r_out.rd, r_out.slot});
    assign o_m_axis_tuser  = r_out.outcome;
    assign o_m_axis_tlast  = r_out.last;

    assign out_hit      = (r_out.outcome == OUT_HIT);
    assign out_evict    = (r_out.outcome == OUT_EVICT);
    assign out_flush_wr = (r_out.outcome == OUT_FLUSH_WR);

    `SCSC_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `SCSC_ASSERT_HOLDS(a_hit_no_disk, o_m_axis_tvalid && out_hit, !r_out.rd && !r_out.wr)
    `SCSC_ASSERT_HOLDS(a_write_kind, o_m_axis_tvalid && r_out.wr, out_evict || out_flush_wr)
    `SCSC_ASSERT_HOLDS(a_single_result, o_m_axis_tvalid && !out_flush_wr, o_m_axis_tlast)

endmodule
